[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg
// Types, register indexes and character tables of the framed command receiver.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam int NUM_REGS   = 8;
  localparam int HEAD_DEPTH = 10;
  localparam int HEAD_AW    = $clog2(HEAD_DEPTH);

  typedef enum logic [2:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_TRAILER_FIRST = 3'd2,
    REG_TRAILER_SECOND = 3'd3,
    REG_LENGTH_HIGH   = 3'd4,
    REG_ASK_CODE      = 3'd5,
    REG_DATA_CODE     = 3'd6,
    REG_ANSWER_CODE   = 3'd7
  } fcr_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_BURST
  } fcr_state_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       flash_active;
    logic       frame_done;
  } fcr_result_t;

  localparam logic [3:0] POS_LEN     = 4'd3;
  localparam logic [3:0] POS_CMD     = 4'd4;
  localparam logic [3:0] POS_PAYLOAD = 4'd5;
  localparam logic [3:0] POS_LAST    = 4'd9;
  localparam logic [3:0] POS_STOP_END = 4'd8;

  localparam logic [7:0] KEY_LENGTH    = 8'd13;
  localparam logic [7:0] ANSWER_LENGTH = 8'd3;
  localparam logic [7:0] STOP_LENGTH   = 8'd5;
  localparam logic [7:0] FLASH_LENGTH  = 8'd6;
  localparam logic [7:0] CHAR_S        = 8'h53;
  localparam logic [7:0] CHAR_F        = 8'h46;

  localparam logic [4:0] KEY_COUNT    = 5'd17;
  localparam logic [4:0] ANSWER_COUNT = 5'd9;

  function automatic logic [7:0] reg_reset(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      REG_HEADER_FIRST:   v = 8'hAA;
      REG_HEADER_SECOND:  v = 8'h55;
      REG_TRAILER_FIRST:  v = 8'h0D;
      REG_TRAILER_SECOND: v = 8'h0A;
      REG_LENGTH_HIGH:    v = 8'h00;
      REG_ASK_CODE:       v = 8'd1;
      REG_DATA_CODE:      v = 8'd2;
      REG_ANSWER_CODE:    v = 8'd3;
      default:            v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] stop_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h53;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h4F;
      3'd3:    c = 8'h50;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] flash_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h46;
      3'd1:    c = 8'h4C;
      3'd2:    c = 8'h41;
      3'd3:    c = 8'h53;
      3'd4:    c = 8'h48;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] greeting_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h6C;
      4'd3:    c = 8'h6C;
      4'd4:    c = 8'h6F;
      4'd5:    c = 8'h5F;
      4'd6:    c = 8'h57;
      4'd7:    c = 8'h6F;
      4'd8:    c = 8'h72;
      4'd9:    c = 8'h6C;
      4'd10:   c = 8'h64;
      4'd11:   c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/fcr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/fcr_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_out_queue
// Two-entry result queue that decouples the receiver logic from the output.
// ----------------------------------------------------------------------------
module fcr_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fcr_pkg::fcr_result_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output fcr_pkg::fcr_result_t head
);
  import fcr_pkg::*;

  fcr_result_t slot0;
  fcr_result_t slot1;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && out_ready;
  assign head      = slot0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
        if (push) begin
          slot1 <= push_data;
        end
      end else if (push) begin
        slot0 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

[rtl/core/framed_uart_command_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_uart_command_receiver
// Finds framed commands in a serial byte stream and answers with frames.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready: action selects a received byte
// (rx_byte) or a key press. Each request yields one or more results on
// out_valid/out_ready; tx_last marks the final result of a request.
// A plain received byte has its status result pushed into the output queue
// on acceptance; a new byte is taken every cycle while in_ready is high.
// A byte that closes a frame starts a read sweep of the frame store RAM
// (positions 3 to 9, one read per cycle, registered read data) and then an
// evaluation state: an ask frame goes on to its reply, any other frame
// queues its status result once the queue is not full.
// An ask frame yields 9 results and a key press 17, one per cycle while the
// queue is not full; no request is taken while such a reply is generated.
// Results pass through a two-entry queue, so a request is still taken while
// one result waits. When the output stalls, the queue fills and in_ready
// drops until a result is taken.
// Reset clears the frame counter, previous byte and flash flag, enters idle
// and loads register defaults; the frame store needs no clearing.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered.
// ----------------------------------------------------------------------------
module framed_uart_command_receiver #(
  parameter int COUNT_WRAP = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       tx_last,
  output logic       flash_active,
  output logic       frame_done,
  input  logic       cfg_we,
  input  logic [3:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import fcr_pkg::*;

  logic [7:0] cfg_regs [NUM_REGS];

  fcr_state_t state;
  fcr_state_t state_next;

  logic [7:0] frame_count;
  logic [7:0] frame_count_next;
  logic [7:0] head0;
  logic [7:0] head0_next;
  logic [7:0] prev_byte;
  logic [7:0] prev_byte_next;
  logic       flash;
  logic       flash_next;
  logic [3:0] rd_addr;
  logic [3:0] rd_addr_next;
  logic [7:0] len_q;
  logic [7:0] len_q_next;
  logic [7:0] cmd_q;
  logic [7:0] cmd_q_next;
  logic [7:0] first_q;
  logic [7:0] first_q_next;
  logic       stop_ok;
  logic       stop_ok_next;
  logic       flash_ok;
  logic       flash_ok_next;
  logic       burst_answer;
  logic       burst_answer_next;
  logic [4:0] burst_idx;
  logic [4:0] burst_idx_next;

  logic              accept;
  logic              ram_we;
  logic [HEAD_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              q_push;
  logic              q_full;
  fcr_result_t       q_item;
  fcr_result_t       q_head;

  logic [7:0] count_held;
  logic [7:0] count_inc;
  logic       mismatch;
  logic       closes;
  logic [3:0] data_pos;
  logic       flash_eval;
  logic [7:0] burst_byte;
  logic       burst_end;

  assign in_ready = (state == ST_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign ram_we   = accept && !action && (frame_count < 8'(HEAD_DEPTH));
  assign ram_raddr = HEAD_AW'(rd_addr);
  assign data_pos = rd_addr - 4'd1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_regs[i] <= reg_reset(3'(i));
      end
    end else if (cfg_we && (cfg_index < 4'(NUM_REGS))) begin
      cfg_regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  fcr_ram #(
    .WIDTH(8),
    .DEPTH(HEAD_DEPTH)
  ) u_head_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(HEAD_AW'(frame_count)),
    .wdata(rx_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Receive path: resync on the header pair and look for the trailer pair.
  always_comb begin
    mismatch   = (frame_count == 8'd1) && (rx_byte != cfg_regs[REG_HEADER_SECOND]);
    head0_next = ((frame_count == 8'd0) || mismatch) ? rx_byte : head0;
    count_held = mismatch ? 8'd0 : frame_count;
    count_inc  = (head0_next == cfg_regs[REG_HEADER_FIRST]) ? count_held + 8'd1 : 8'd0;
    closes     = (count_inc > 8'd7) && (prev_byte == cfg_regs[REG_TRAILER_FIRST])
                 && (rx_byte == cfg_regs[REG_TRAILER_SECOND]);
  end

  // Flash flag decision from the gathered frame fields.
  always_comb begin
    flash_eval = flash;
    if ((cmd_q != cfg_regs[REG_ASK_CODE]) && (cmd_q == cfg_regs[REG_DATA_CODE])) begin
      if ((len_q == STOP_LENGTH) && (first_q == CHAR_S)) begin
        if (stop_ok) begin
          flash_eval = 1'b0;
        end
      end else if ((len_q == FLASH_LENGTH) && (first_q == CHAR_F)) begin
        if (flash_ok) begin
          flash_eval = 1'b1;
        end
      end else begin
        flash_eval = 1'b0;
      end
    end
  end

  // Reply frame bytes.
  always_comb begin
    burst_byte = 8'h00;
    if (burst_answer) begin
      case (burst_idx)
        5'd0:    burst_byte = cfg_regs[REG_HEADER_FIRST];
        5'd1:    burst_byte = cfg_regs[REG_HEADER_SECOND];
        5'd2:    burst_byte = cfg_regs[REG_LENGTH_HIGH];
        5'd3:    burst_byte = ANSWER_LENGTH;
        5'd4:    burst_byte = cfg_regs[REG_ANSWER_CODE];
        5'd7:    burst_byte = cfg_regs[REG_TRAILER_FIRST];
        5'd8:    burst_byte = cfg_regs[REG_TRAILER_SECOND];
        default: burst_byte = 8'h00;
      endcase
    end else begin
      case (burst_idx)
        5'd0:    burst_byte = cfg_regs[REG_HEADER_FIRST];
        5'd1:    burst_byte = cfg_regs[REG_HEADER_SECOND];
        5'd2:    burst_byte = cfg_regs[REG_LENGTH_HIGH];
        5'd3:    burst_byte = KEY_LENGTH;
        5'd4:    burst_byte = cfg_regs[REG_DATA_CODE];
        default: burst_byte = greeting_char(4'(burst_idx - 5'd5));
      endcase
    end
    burst_end = burst_answer ? (burst_idx == ANSWER_COUNT - 5'd1)
                             : (burst_idx == KEY_COUNT - 5'd1);
  end

  always_comb begin
    state_next        = state;
    frame_count_next  = frame_count;
    prev_byte_next    = prev_byte;
    flash_next        = flash;
    rd_addr_next      = rd_addr;
    len_q_next        = len_q;
    cmd_q_next        = cmd_q;
    first_q_next      = first_q;
    stop_ok_next      = stop_ok;
    flash_ok_next     = flash_ok;
    burst_answer_next = burst_answer;
    burst_idx_next    = burst_idx;
    q_push            = 1'b0;
    q_item            = '{tx_valid: 1'b0, tx_byte: 8'h00, tx_last: 1'b1,
                          flash_active: flash, frame_done: 1'b0};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action) begin
            burst_answer_next = 1'b0;
            burst_idx_next    = 5'd0;
            state_next        = ST_BURST;
          end else begin
            prev_byte_next = rx_byte;
            if (closes) begin
              frame_count_next = 8'd0;
              rd_addr_next     = POS_LEN;
              stop_ok_next     = 1'b1;
              flash_ok_next    = 1'b1;
              state_next       = ST_READ;
            end else begin
              frame_count_next = (count_inc >= 8'(COUNT_WRAP)) ? 8'd0 : count_inc;
              q_push           = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        // Data for the address issued last cycle arrives now.
        if (rd_addr > POS_LEN) begin
          if (data_pos == POS_LEN) begin
            len_q_next = ram_rdata;
          end
          if (data_pos == POS_CMD) begin
            cmd_q_next = ram_rdata;
          end
          if (data_pos == POS_PAYLOAD) begin
            first_q_next = ram_rdata;
          end
          if ((data_pos >= POS_PAYLOAD) && (data_pos <= POS_STOP_END)
              && (ram_rdata != stop_char(3'(data_pos - POS_PAYLOAD)))) begin
            stop_ok_next = 1'b0;
          end
          if ((data_pos >= POS_PAYLOAD)
              && (ram_rdata != flash_char(3'(data_pos - POS_PAYLOAD)))) begin
            flash_ok_next = 1'b0;
          end
        end
        rd_addr_next = rd_addr + 4'd1;
        if (rd_addr == POS_LAST + 4'd1) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (cmd_q == cfg_regs[REG_ASK_CODE]) begin
          burst_answer_next = 1'b1;
          burst_idx_next    = 5'd0;
          state_next        = ST_BURST;
        end else if (!q_full) begin
          flash_next          = flash_eval;
          q_item.flash_active = flash_eval;
          q_item.frame_done   = 1'b1;
          q_push              = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      ST_BURST: begin
        q_item = '{tx_valid: 1'b1, tx_byte: burst_byte, tx_last: burst_end,
                   flash_active: flash, frame_done: burst_answer};
        if (!q_full) begin
          q_push         = 1'b1;
          burst_idx_next = burst_idx + 5'd1;
          if (burst_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_count <= 8'd0;
      prev_byte   <= 8'd0;
      flash       <= 1'b0;
    end else begin
      state       <= state_next;
      frame_count <= frame_count_next;
      prev_byte   <= prev_byte_next;
      flash       <= flash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !action) begin
      head0 <= head0_next;
    end
    rd_addr      <= rd_addr_next;
    len_q        <= len_q_next;
    cmd_q        <= cmd_q_next;
    first_q      <= first_q_next;
    stop_ok      <= stop_ok_next;
    flash_ok     <= flash_ok_next;
    burst_answer <= burst_answer_next;
    burst_idx    <= burst_idx_next;
  end

  fcr_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_item),
    .full     (q_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (q_head)
  );

  assign tx_valid     = q_head.tx_valid;
  assign tx_byte      = q_head.tx_byte;
  assign tx_last      = q_head.tx_last;
  assign flash_active = q_head.flash_active;
  assign frame_done   = q_head.frame_done;

endmodule

[rtl/core/fcr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_checker
// Port-level checks of the framed command receiver, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       tx_last,
  input logic       flash_active
);

  // A stalled result keeps its byte.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(tx_byte), "stalled result changed")

  // A status-only result is always the single, final result of its request.
  `ASSERT_IMPLIES(a_status_last, clk, rst, out_valid && !tx_valid, tx_last && (tx_byte == 8'h00), "bad status result")

  // No new request is taken while a reply frame is only partly delivered.
  `ASSERT_IMPLIES(a_no_accept_mid_reply, clk, rst, out_valid && !tx_last, !in_ready, "request taken mid reply")

  // All results of one request report the same flash flag.
  `ASSERT_NEXT(a_flash_steady, clk, rst, out_valid && out_ready && !tx_last, out_valid && (flash_active == $past(flash_active)), "flash flag changed within a reply")

endmodule

bind framed_uart_command_receiver fcr_checker u_fcr_checker (.*);
